@@ hdl/xtea_pkg.sv @@
package xtea_pkg;

	localparam int ROUNDS = 32;
	localparam int STAGES = 2 * ROUNDS;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = $clog2(KEY_WORDS);

	localparam logic [31:0] DELTA = 32'h9E37_79B9;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = CFG_IDX_W'(3);

	localparam logic [31:0] KEY_WORD0_RST = 32'h0000_FDA5;
	localparam logic [31:0] KEY_WORD1_RST = 32'h0000_D54E;
	localparam logic [31:0] KEY_WORD2_RST = 32'h0000_FC00;
	localparam logic [31:0] KEY_WORD3_RST = 32'h0000_B55A;

	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	typedef logic [KEY_WORDS-1:0][31:0] key_t;

	typedef struct packed {
		logic        dec;
		logic [31:0] x;
		logic [31:0] y;
	} word_t;

	// per-stage constants: sums and key selects for both directions, and which half updates
	typedef struct packed {
		logic [31:0] sum_enc;
		logic [31:0] sum_dec;
		logic [1:0]  kidx_enc;
		logic [1:0]  kidx_dec;
		logic        upd_x_enc;
	} stage_t;

	function automatic stage_t stage_const(input int k);
		int n;
		stage_t c;
		n = k >> 1;
		if ((k & 1) == 0) begin
			c.sum_enc   = DELTA * 32'(n);
			c.kidx_enc  = c.sum_enc[1:0];
			c.sum_dec   = DELTA * 32'(ROUNDS - n);
			c.kidx_dec  = c.sum_dec[12:11];
			c.upd_x_enc = 1'b1;
		end else begin
			c.sum_enc   = DELTA * 32'(n + 1);
			c.kidx_enc  = c.sum_enc[12:11];
			c.sum_dec   = DELTA * 32'(ROUNDS - n - 1);
			c.kidx_dec  = c.sum_dec[1:0];
			c.upd_x_enc = 1'b0;
		end
		return c;
	endfunction

endpackage

@@ hdl/xtea_if.sv @@
interface xtea_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] block_first;
	logic [31:0] block_second;

	modport source(output valid, req_type, block_first, block_second, input ready);
	modport sink(input valid, req_type, block_first, block_second, output ready);
endinterface

interface xtea_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_first;
	logic [31:0] result_second;

	modport source(output valid, result_first, result_second, input ready);
	modport sink(input valid, result_first, result_second, output ready);
endinterface

@@ hdl/xtea_stage.sv @@
module xtea_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  xtea_pkg::word_t  word_in,
	input  xtea_pkg::key_t   key,
	input  xtea_pkg::stage_t cst,
	output logic             vld_out,
	output xtea_pkg::word_t  word_out
);

	logic             vld_s1;
	xtea_pkg::word_t  word_s1;
	xtea_pkg::word_t  word_nx;
	logic             upd_x;
	logic [31:0]      ksum;
	logic [31:0]      src;
	logic [31:0]      dst;
	logic [31:0]      mix;
	logic [31:0]      f;
	logic [31:0]      res;

	always_comb begin
		upd_x = cst.upd_x_enc ^ word_in.dec;
		ksum  = word_in.dec ? (cst.sum_dec + key[cst.kidx_dec])
		                    : (cst.sum_enc + key[cst.kidx_enc]);
		src   = upd_x ? word_in.y : word_in.x;
		dst   = upd_x ? word_in.x : word_in.y;
		mix   = ((src << 4) ^ (src >> 5)) + src;
		f     = mix ^ ksum;
		res   = word_in.dec ? (dst - f) : (dst + f);
		word_nx     = word_in;
		if (upd_x) begin
			word_nx.x = res;
		end else begin
			word_nx.y = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= word_nx;
		end
	end

	assign vld_out  = vld_s1;
	assign word_out = word_s1;

endmodule

@@ hdl/xtea_block_cipher.sv @@
// XTEA cipher, 64-bit block, 128-bit key, one half-round per pipeline stage.
// req channel: one word per block with req_type (0 encrypt, 1 decrypt) and
// the two block halves. rsp channel: one word per block with the result.
// Key: four 32-bit registers written through cfg_we/cfg_idx/cfg_wdata;
// write only while no block is in flight.
// Path: each block passes through the chain of registered half-round
// stages, each a mix add, a key add, an xor and an add (a subtract
// when decrypting).
// Throughput: one block per cycle, sustained while the receiver does not stall.
// Reset: all stage valid bits clear, key returns to its default value.
// Receiver stall: the result on rsp holds; earlier stages keep advancing
// into empty slots, so req.ready drops only when every stage is full.
module xtea_block_cipher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [31:0]                      cfg_wdata,
	xtea_req_if.sink                         req,
	xtea_rsp_if.source                       rsp
);

	localparam int LAST = xtea_pkg::STAGES - 1;

	xtea_pkg::key_t  key_q;
	xtea_pkg::word_t word_in;
	xtea_pkg::word_t word [xtea_pkg::STAGES];
	logic            vld  [xtea_pkg::STAGES];
	logic            en   [xtea_pkg::STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= xtea_pkg::KEY_WORD0_RST;
			key_q[1] <= xtea_pkg::KEY_WORD1_RST;
			key_q[2] <= xtea_pkg::KEY_WORD2_RST;
			key_q[3] <= xtea_pkg::KEY_WORD3_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				xtea_pkg::REG_KEY_WORD0: key_q[0] <= cfg_wdata;
				xtea_pkg::REG_KEY_WORD1: key_q[1] <= cfg_wdata;
				xtea_pkg::REG_KEY_WORD2: key_q[2] <= cfg_wdata;
				xtea_pkg::REG_KEY_WORD3: key_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign word_in.dec = req.req_type;
	assign word_in.x   = req.block_first;
	assign word_in.y   = req.block_second;

	// a stage moves when it is empty or the stage after it moves
	assign en[xtea_pkg::STAGES] = rsp.ready;

	genvar g;
	generate
		for (g = 0; g < xtea_pkg::STAGES; g++) begin : g_stage
			localparam xtea_pkg::stage_t CST = xtea_pkg::stage_const(g);

			assign en[g] = !vld[g] || en[g+1];

			if (g == 0) begin : g_first
				xtea_stage u_stage (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en[g]),
					.vld_in   (req.valid),
					.word_in  (word_in),
					.key      (key_q),
					.cst      (CST),
					.vld_out  (vld[g]),
					.word_out (word[g])
				);
			end else begin : g_next
				xtea_stage u_stage (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en[g]),
					.vld_in   (vld[g-1]),
					.word_in  (word[g-1]),
					.key      (key_q),
					.cst      (CST),
					.vld_out  (vld[g]),
					.word_out (word[g])
				);
			end
		end
	endgenerate

	assign req.ready         = en[0];
	assign rsp.valid         = vld[LAST];
	assign rsp.result_first  = word[LAST].x;
	assign rsp.result_second = word[LAST].y;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld[0])
		else $error("accepted word did not enter first stage");

	a_stall_holds_first: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] && !en[0] |=> vld[0] && $stable(word[0]))
		else $error("stalled first stage changed");

	a_bubble_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[0] |-> req.ready)
		else $error("empty first stage refused a word");

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> vld[LAST] && !rsp.ready)
		else $error("input stalled without a blocked result");

endmodule

@@ tb/tb_xtea_block_cipher.sv @@
`timescale 1ns / 1ps

module tb_xtea_block_cipher;

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] second;
	} block_words_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [31:0]                    cfg_wdata;

	xtea_req_if req_ch ();
	xtea_rsp_if rsp_ch ();

	xtea_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	xtea_pkg::key_t  key_shadow;
	xtea_pkg::word_t pending_blocks[$];
	block_words_t    expected_blocks[$];
	xtea_pkg::word_t next_block;
	block_words_t    expected_head;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              mismatch_count;
	int              n_encrypt;
	int              n_decrypt;
	int              n_keys;

	function automatic logic [31:0] mix_word(input logic [31:0] w);
		return ((w << 4) ^ (w >> 5)) + w;
	endfunction

	function automatic block_words_t xtea_transform(input logic dec, input logic [31:0] a,
			input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] s;
		block_words_t r;
		x = a;
		y = b;
		if (dec == xtea_pkg::REQ_DECRYPT) begin
			s = xtea_pkg::DELTA * 32'(xtea_pkg::ROUNDS);
			for (int n = 0; n < xtea_pkg::ROUNDS; n++) begin
				y = y - (mix_word(x) ^ (s + key_shadow[s[12:11]]));
				s = s - xtea_pkg::DELTA;
				x = x - (mix_word(y) ^ (s + key_shadow[s[1:0]]));
			end
		end else begin
			s = 32'h0;
			for (int n = 0; n < xtea_pkg::ROUNDS; n++) begin
				x = x + (mix_word(y) ^ (s + key_shadow[s[1:0]]));
				s = s + xtea_pkg::DELTA;
				y = y + (mix_word(x) ^ (s + key_shadow[s[12:11]]));
			end
		end
		r.first = x;
		r.second = y;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic queue_block(input logic dec, input logic [31:0] a, input logic [31:0] b);
		xtea_pkg::word_t w;
		w.dec = dec;
		w.x = a;
		w.y = b;
		pending_blocks.push_back(w);
	endtask

	// encrypt then decrypt the predicted ciphertext, or the other way round
	task automatic queue_round_trip(input logic first_op, input logic [31:0] a,
			input logic [31:0] b);
		block_words_t mid;
		mid = xtea_transform(first_op, a, b);
		queue_block(first_op, a, b);
		queue_block(~first_op, mid.first, mid.second);
	endtask

	task automatic wait_idle();
		while (pending_blocks.size() != 0 || req_ch.valid || expected_blocks.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		key_shadow[idx] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_key(input xtea_pkg::key_t k);
		write_reg(xtea_pkg::REG_KEY_WORD0, k[0]);
		write_reg(xtea_pkg::REG_KEY_WORD1, k[1]);
		write_reg(xtea_pkg::REG_KEY_WORD2, k[2]);
		write_reg(xtea_pkg::REG_KEY_WORD3, k[3]);
		n_keys++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_blocks.push_back(xtea_transform(req_ch.req_type,
					req_ch.block_first, req_ch.block_second));
				if (req_ch.req_type == xtea_pkg::REQ_DECRYPT)
					n_decrypt++;
				else
					n_encrypt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_block = pending_blocks.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_block.dec;
					req_ch.block_first <= next_block.x;
					req_ch.block_second <= next_block.y;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_blocks.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word, expected none, actual %h %h", $time,
					rsp_ch.result_first, rsp_ch.result_second);
			end else begin
				expected_head = expected_blocks.pop_front();
				if (rsp_ch.result_first !== expected_head.first) begin
					mismatch_count++;
					$display("%0t: result_first expected %h actual %h", $time,
						expected_head.first, rsp_ch.result_first);
				end
				if (rsp_ch.result_second !== expected_head.second) begin
					mismatch_count++;
					$display("%0t: result_second expected %h actual %h", $time,
						expected_head.second, rsp_ch.result_second);
				end
			end
		end
	end

	initial begin
		xtea_pkg::key_t k;
		int             queued;
		int             r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = xtea_pkg::REQ_ENCRYPT;
		req_ch.block_first = '0;
		req_ch.block_second = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		n_encrypt = 0;
		n_decrypt = 0;
		n_keys = 1;
		key_shadow[0] = xtea_pkg::KEY_WORD0_RST;
		key_shadow[1] = xtea_pkg::KEY_WORD1_RST;
		key_shadow[2] = xtea_pkg::KEY_WORD2_RST;
		key_shadow[3] = xtea_pkg::KEY_WORD3_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words on the reset key
		for (int op = 0; op < 2; op++) begin
			queue_block(op[0], 32'h0000_0000, 32'h0000_0000);
			queue_block(op[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			queue_block(op[0], 32'h0000_0000, 32'hFFFF_FFFF);
			queue_block(op[0], 32'hFFFF_FFFF, 32'h0000_0000);
			queue_block(op[0], 32'h8000_0000, 32'h0000_0001);
			queue_block(op[0], 32'h0000_0001, 32'h8000_0000);
			queue_block(op[0], 32'hAAAA_AAAA, 32'h5555_5555);
		end
		queue_round_trip(xtea_pkg::REQ_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
		queue_round_trip(xtea_pkg::REQ_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: k = '0;
				1: k = '1;
				2: k = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
				default: k = {$urandom, $urandom, $urandom, $urandom};
			endcase
			set_key(k);
			@(negedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			queued = 0;
			while (queued < 140) begin
				if (queued >= 70 && queued < 72)
					wait_idle();
				r = $urandom_range(99);
				if (r < 30) begin
					queue_round_trip(xtea_pkg::REQ_ENCRYPT, rand_word(), rand_word());
					queued += 2;
				end else if (r < 45) begin
					queue_round_trip(xtea_pkg::REQ_DECRYPT, rand_word(), rand_word());
					queued += 2;
				end else begin
					queue_block(1'($urandom_range(1)), rand_word(), rand_word());
					queued++;
				end
			end
			wait_idle();
		end

		// key back to its reset value
		k[0] = xtea_pkg::KEY_WORD0_RST;
		k[1] = xtea_pkg::KEY_WORD1_RST;
		k[2] = xtea_pkg::KEY_WORD2_RST;
		k[3] = xtea_pkg::KEY_WORD3_RST;
		set_key(k);
		@(negedge clk);
		for (int i = 0; i < 8; i++)
			queue_block(1'($urandom_range(1)), $urandom, $urandom);
		wait_idle();
		repeat (80) @(posedge clk);

		$display("Run: %0d encrypt and %0d decrypt blocks over %0d keys,", n_encrypt,
			n_decrypt, n_keys);
		$display("     with sender gaps and receiver stalls mixed in; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
